[rtl/itp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, codes, types and the precedence table of the
// infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int KIND_W  = 3;
	localparam int OP_W    = 4;
	localparam int PAY_W   = 64;
	localparam int OKIND_W = 2;
	localparam int ST_W    = 2;

	// input token kinds
	localparam logic [KIND_W-1:0] KIND_NUM    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_VAR    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LPAREN = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RPAREN = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OP     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_END    = 3'd5;

	// result kinds
	localparam logic [OKIND_W-1:0] OKIND_OPER = 2'd2;
	localparam logic [OKIND_W-1:0] OKIND_MARK = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_UNMATCHED = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

	// operator codes
	localparam logic [OP_W-1:0] OP_PLUS    = 4'd0;
	localparam logic [OP_W-1:0] OP_MINUS   = 4'd1;
	localparam logic [OP_W-1:0] OP_STAR    = 4'd2;
	localparam logic [OP_W-1:0] OP_SLASH   = 4'd3;
	localparam logic [OP_W-1:0] OP_PERCENT = 4'd4;
	localparam logic [OP_W-1:0] OP_LESS    = 4'd5;
	localparam logic [OP_W-1:0] OP_MORE    = 4'd6;
	localparam logic [OP_W-1:0] OP_LESSEQ  = 4'd7;
	localparam logic [OP_W-1:0] OP_MOREEQ  = 4'd8;
	localparam logic [OP_W-1:0] OP_EQUAL   = 4'd9;
	localparam logic [OP_W-1:0] OP_AND     = 4'd10;
	localparam logic [OP_W-1:0] OP_OR      = 4'd11;
	localparam logic [OP_W-1:0] OP_COUNT   = 4'd12;

	// stack entry that marks an open paren
	localparam logic [OP_W-1:0] LPAREN_CODE = 4'd15;

	typedef struct packed {
		logic [OKIND_W-1:0] kind;
		logic [OP_W-1:0]    op;
		logic [PAY_W-1:0]   payload;
		logic [ST_W-1:0]    status;
	} result_t;

	typedef struct packed {
		logic    load;
		logic    flush;
		result_t res;
	} emit_req_t;

	typedef struct packed {
		logic ack;
		logic pend_v;
	} emit_rsp_t;

	function automatic logic [2:0] prec_of(input logic [OP_W-1:0] op);
		logic [2:0] p;
		unique case (op)
			OP_AND, OP_OR:                           p = 3'd1;
			OP_PLUS, OP_MINUS:                       p = 3'd2;
			OP_STAR, OP_SLASH, OP_PERCENT:           p = 3'd3;
			OP_LESS, OP_MORE, OP_LESSEQ, OP_MOREEQ: p = 3'd4;
			OP_EQUAL:                                p = 3'd5;
			default:                                 p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

[rtl/itp_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_in_if
// Token channel: valid/ready handshake carrying one infix token.
// ----------------------------------------------------------------------------
interface itp_in_if
	import itp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [OP_W-1:0]   op_code;
	logic [PAY_W-1:0]  payload;

	modport source (output valid, output kind, output op_code, output payload, input ready);
	modport sink (input valid, input kind, input op_code, input payload, output ready);
endinterface

[rtl/itp_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_out_if
// Result channel: valid/ready handshake carrying one postfix word.
// ----------------------------------------------------------------------------
interface itp_out_if
	import itp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OKIND_W-1:0] out_kind;
	logic [OP_W-1:0]    out_op;
	logic [PAY_W-1:0]   out_payload;
	logic [ST_W-1:0]    status;
	logic               last;

	modport source (output valid, output out_kind, output out_op, output out_payload,
		output status, output last, input ready);
	modport sink (input valid, input out_kind, input out_op, input out_payload,
		input status, input last, output ready);
endinterface

[rtl/itp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module itp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/itp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl
// Token sequencer: owns the stack pointer, reads the top of the operator
// stack from RAM and decides pops, pushes and markers.
// ----------------------------------------------------------------------------
module itp_ctrl
	import itp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	itp_in_if.sink            tokens,
	output emit_req_t         req,
	input  emit_rsp_t         rsp,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [OP_W-1:0]   ram_wdata,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [OP_W-1:0]   ram_rdata
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PASS  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_PUSH  = 3'd3;
	localparam logic [2:0] S_MARK  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  cnt_m1, cnt_m2;
	logic [KIND_W-1:0] kind_q;
	logic [OP_W-1:0]   op_q;
	logic [PAY_W-1:0]  pay_q;
	logic [ST_W-1:0]   mark_st_q, mark_st_d;
	logic              accept;
	logic              full;
	logic              pop;
	logic              pop_go;

	assign accept = tokens.valid && tokens.ready;
	assign tokens.ready = (state_q == S_IDLE);
	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign cnt_m2 = cnt_q - CNT_W'(2);
	assign full = (cnt_q == CNT_W'(STACK_DEPTH));

	// top of stack stops an operator at '(' or at lower precedence
	always_comb begin
		if (kind_q == KIND_OP) begin
			pop = (ram_rdata < OP_COUNT) && (prec_of(op_q) <= prec_of(ram_rdata));
		end else begin
			pop = (ram_rdata != LPAREN_CODE);
		end
	end

	assign pop_go = (state_q == S_CHECK) && pop && rsp.ack;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		mark_st_d = mark_st_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[ADDR_W-1:0];
		ram_wdata = op_q;
		ram_re    = 1'b0;
		ram_raddr = cnt_m1[ADDR_W-1:0];
		req       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (tokens.kind)
						KIND_NUM, KIND_VAR: begin
							state_d = S_PASS;
						end
						KIND_LPAREN: begin
							if (full) begin
								mark_st_d = ST_OVERFLOW;
								state_d   = S_MARK;
							end else begin
								ram_we    = 1'b1;
								ram_wdata = LPAREN_CODE;
								cnt_d     = cnt_q + CNT_W'(1);
							end
						end
						KIND_RPAREN: begin
							if (cnt_q == '0) begin
								mark_st_d = ST_UNMATCHED;
								state_d   = S_MARK;
							end else begin
								ram_re  = 1'b1;
								state_d = S_CHECK;
							end
						end
						KIND_OP: begin
							if (tokens.op_code < OP_COUNT) begin
								if (cnt_q == '0) begin
									state_d = S_PUSH;
								end else begin
									ram_re  = 1'b1;
									state_d = S_CHECK;
								end
							end
						end
						KIND_END: begin
							if (cnt_q == '0) begin
								mark_st_d = ST_OK;
								state_d   = S_MARK;
							end else begin
								ram_re  = 1'b1;
								state_d = S_CHECK;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_PASS: begin
				req.load        = 1'b1;
				req.flush       = 1'b1;
				req.res.kind    = kind_q[OKIND_W-1:0];
				req.res.payload = pay_q;
				if (rsp.ack) begin
					state_d = S_IDLE;
				end
			end
			S_CHECK: begin
				if (pop) begin
					req.load     = 1'b1;
					req.res.kind = OKIND_OPER;
					req.res.op   = ram_rdata;
					if (rsp.ack) begin
						cnt_d = cnt_m1;
						if (cnt_m1 == '0) begin
							priority case (kind_q)
								KIND_RPAREN: begin
									mark_st_d = ST_UNMATCHED;
									state_d   = S_MARK;
								end
								KIND_OP: begin
									state_d = S_PUSH;
								end
								default: begin
									mark_st_d = ST_OK;
									state_d   = S_MARK;
								end
							endcase
						end else begin
							// fetch the next entry down
							ram_re    = 1'b1;
							ram_raddr = cnt_m2[ADDR_W-1:0];
						end
					end
				end else begin
					priority case (kind_q)
						KIND_RPAREN: begin
							cnt_d   = cnt_m1;
							state_d = S_FIN;
						end
						KIND_OP: begin
							state_d = S_PUSH;
						end
						default: begin
							cnt_d     = '0;
							mark_st_d = ST_OK;
							state_d   = S_MARK;
						end
					endcase
				end
			end
			S_PUSH: begin
				if (full) begin
					mark_st_d = ST_OVERFLOW;
					state_d   = S_MARK;
				end else begin
					ram_we  = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = S_FIN;
				end
			end
			S_MARK: begin
				req.load       = 1'b1;
				req.res.kind   = OKIND_MARK;
				req.res.status = mark_st_q;
				if (rsp.ack) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				req.flush = 1'b1;
				if (rsp.ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		mark_st_q <= mark_st_d;
		if (accept) begin
			kind_q <= tokens.kind;
			op_q   <= tokens.op_code;
			pay_q  <= tokens.payload;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_check_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> cnt_q != '0)
		else $error("top of stack examined on empty stack");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		pop_go |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("pop did not lower the stack count");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !rsp.pend_v)
		else $error("held word left over between tokens");
`endif
endmodule

[rtl/itp_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_emit
// Result stage: holds one word back until it is known whether it is the
// last of its token, and drives the output register.
// ----------------------------------------------------------------------------
module itp_emit
	import itp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  emit_req_t req,
	output emit_rsp_t rsp,
	itp_out_if.source results
);
	logic    ovalid_q;
	result_t oreg_q;
	logic    olast_q;
	logic    pend_v_q;
	result_t pend_q;
	logic    out_free;
	logic    ack;
	logic    out_load;
	logic    direct;

	assign out_free = !ovalid_q || results.ready;
	assign direct   = req.load && req.flush;

	always_comb begin
		priority if (direct) begin
			ack = out_free;
		end else if (req.load || req.flush) begin
			ack = !pend_v_q || out_free;
		end else begin
			ack = 1'b0;
		end
	end

	// a word leaves when passed straight through or when pushed out of hold
	assign out_load = ack && (direct || (pend_v_q && (req.load || req.flush)));

	assign rsp.ack    = ack;
	assign rsp.pend_v = pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
			if (ack && req.load && !req.flush) begin
				pend_v_q <= 1'b1;
			end else if (ack && req.flush && !req.load) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			oreg_q  <= direct ? req.res : pend_q;
			olast_q <= req.flush;
		end
		if (ack && req.load && !req.flush) begin
			pend_q <= req.res;
		end
	end

	assign results.valid       = ovalid_q;
	assign results.out_kind    = oreg_q.kind;
	assign results.out_op      = oreg_q.op;
	assign results.out_payload = oreg_q.payload;
	assign results.status      = oreg_q.status;
	assign results.last        = olast_q;

`ifndef ASSERT_OFF
	a_direct_empty: assert property (@(posedge clk) disable iff (!arst_n)
		direct |-> !pend_v_q)
		else $error("pass-through word while a word is held");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !results.ready |=> ovalid_q && $stable(oreg_q) && $stable(olast_q))
		else $error("output word changed while stalled");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ack && req.flush |=> !pend_v_q)
		else $error("held word survived a flush");
`endif
endmodule

[rtl/infix_to_postfix_converter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: infix tokens in, postfix words out, operator
// stack held in a synchronous RAM.
//
//   channel   dir  handshake     payload
//   tokens    in   valid/ready   kind, op_code, payload
//   results   out  valid/ready   out_kind, out_op, out_payload, status, last
//
// number/variable: passed out as is; '(': pushed, or an overflow marker if full;
// ')': pops operators down to its '(', or marks it unmatched; operator: pops while
// the top has equal or higher precedence, then pushes or marks an overflow; end:
// pops to a '(' and emits a marker; the registered RAM read sets the check step.
// reset clears the stack count and the handshake state; the RAM needs no clear.
// a stalled results channel holds the sequencer at its next word; the output
// register lets a new token enter while the previous word still waits.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit
	import itp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	itp_in_if.sink    tokens,
	itp_out_if.source results
);
	emit_req_t         req;
	emit_rsp_t         rsp;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [OP_W-1:0]   ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [OP_W-1:0]   ram_rdata;

	itp_ram #(
		.WIDTH (OP_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	itp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tokens    (tokens),
		.req       (req),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	itp_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.results (results)
	);
endmodule
